// ===== rtl/core/abd_pkg.sv =====
// abd_pkg: constants, register indexes and the sigmoid table for the anchor box decoder
// standalone package, no dependencies
`default_nettype none

package abd_pkg;

  localparam int ANCHORS_PER_SCALE   = 3;
  localparam int MAX_CLASSES         = 128;
  localparam int SIGMOID_TABLE_DEPTH = 1024;

  localparam int SIG_IDX_W  = $clog2(SIGMOID_TABLE_DEPTH);
  localparam int SIG_PROD_W = 12 + $clog2(SIGMOID_TABLE_DEPTH + 1);
  localparam int SLOT_W     = 2;

  localparam int IN_DATA_W  = 48;
  localparam int OUT_DATA_W = 88;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  localparam int PROD_W = 52;
  localparam int EDGE_W = 56;

  localparam logic [CFG_IDX_W-1:0] REG_SCORE_THRESHOLD = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_STRIDE     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_CLASS_COUNT     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_ANCHOR_SIZE_0   = 3'd5;

  localparam logic [7:0] CH_OFFSET_X   = 8'd0;
  localparam logic [7:0] CH_OFFSET_Y   = 8'd1;
  localparam logic [7:0] CH_SIZE_W     = 8'd2;
  localparam logic [7:0] CH_SIZE_H     = 8'd3;
  localparam logic [7:0] CH_OBJECTNESS = 8'd4;
  localparam logic [7:0] CH_FIRST_CLS  = 8'd5;

  localparam longint unsigned DEC_ONE = 64'd1000000000;
  localparam longint unsigned EXP_FACTOR [12] = '{
    64'd996101369, 64'd992217938, 64'd984496437, 64'd969233234,
    64'd939413063, 64'd882496903, 64'd778800783, 64'd606530660,
    64'd367879441, 64'd135335283, 64'd18315639,  64'd335463
  };

  typedef logic [15:0] sig_table_t [SIGMOID_TABLE_DEPTH];

  // shift-subtract quotient, valid while the quotient stays below 2**16
  function automatic longint unsigned div_q16(input longint unsigned num,
                                              input longint unsigned den);
    longint unsigned q;
    longint unsigned r;
    q = 64'd0;
    r = num;
    for (int b = 15; b >= 0; b--) begin
      if (r >= (den << b)) begin
        r = r - (den << b);
        q = q | (64'd1 << b);
      end
    end
    return q;
  endfunction

  function automatic sig_table_t build_sig_table();
    sig_table_t       t;
    longint unsigned  e;
    longint unsigned  den;
    int               v;
    int               mag;
    for (int i = 0; i < SIGMOID_TABLE_DEPTH; i++) begin
      v   = (i * 4096) / SIGMOID_TABLE_DEPTH - 2048;
      mag = (v < 0) ? -v : v;
      e   = DEC_ONE;
      for (int b = 0; b < 12; b++) begin
        if (((mag >> b) & 1) != 0) begin
          e = (e * EXP_FACTOR[b] + DEC_ONE / 2) / DEC_ONE;
        end
      end
      den = DEC_ONE + e;
      if (v >= 0) begin
        t[i] = 16'(div_q16(64'd32768 * DEC_ONE + (den >> 1), den));
      end else begin
        t[i] = 16'(div_q16(64'd32768 * e + (den >> 1), den));
      end
    end
    return t;
  endfunction

  localparam sig_table_t SIG_TABLE = build_sig_table();

  // saturate to [-8, 8) and scale onto the table
  function automatic logic [SIG_IDX_W-1:0] sig_index(input logic signed [15:0] x);
    logic [11:0]           u;
    logic [SIG_PROD_W-1:0] p;
    if (x < -16'sd2048) begin
      u = 12'd0;
    end else if (x > 16'sd2047) begin
      u = 12'd4095;
    end else begin
      u = x[11:0] ^ 12'h800;
    end
    p = SIG_PROD_W'(u) * SIG_PROD_W'(SIGMOID_TABLE_DEPTH);
    return p[SIG_IDX_W+11:12];
  endfunction

  function automatic logic [15:0] clip_bound(input logic [12:0] size);
    logic [16:0] b;
    b = {size - 13'd1, 4'd0};
    if (size == 13'd0) begin
      return 16'd0;
    end else if (b > 17'd65535) begin
      return 16'hFFFF;
    end else begin
      return b[15:0];
    end
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/anchor_box_decode_top.sv =====
// anchor_box_decode_top: logit stream to clipped boxes, one shared multiplier under a sequencer
// depends on abd_pkg
// box channels pass through ST_SIGW; non-final class and ignored beats stay in ST_IDLE
// final class beat: ST_CLSRD, ST_SCORE and ST_THR, then idle if below threshold, otherwise the
// multiplies on the single shared 34x18 multiplier, ST_EDGE/ST_CLIP per edge in turn, ST_EMIT;
// synchronous active-low reset: config to defaults, held probabilities zero, best class cleared
`default_nettype none

module anchor_box_decode_top (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  // logit, cell_column, cell_row, anchor_slot, channel, pad
  input  wire logic [abd_pkg::IN_DATA_W-1:0]  in_tdata,
  input  wire logic                           in_tvalid,
  output logic                                in_tready,
  // left_edge, top_edge, right_edge, bottom_edge, confidence, class_id, pad
  output logic [abd_pkg::OUT_DATA_W-1:0]      out_tdata,
  output logic                                out_tvalid,
  input  wire logic                           out_tready,
  input  wire logic                           cfg_wr_en,
  input  wire logic [abd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [abd_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_SIGW  = 4'd1;
  localparam logic [3:0] ST_CLSRD = 4'd2;
  localparam logic [3:0] ST_SCORE = 4'd3;
  localparam logic [3:0] ST_THR   = 4'd4;
  localparam logic [3:0] ST_MCX   = 4'd5;
  localparam logic [3:0] ST_MCY   = 4'd6;
  localparam logic [3:0] ST_MW2   = 4'd7;
  localparam logic [3:0] ST_MHW   = 4'd8;
  localparam logic [3:0] ST_MH2   = 4'd9;
  localparam logic [3:0] ST_MHH   = 4'd10;
  localparam logic [3:0] ST_HHLD  = 4'd11;
  localparam logic [3:0] ST_EDGE  = 4'd12;
  localparam logic [3:0] ST_CLIP  = 4'd13;
  localparam logic [3:0] ST_EMIT  = 4'd14;

  localparam int EW = abd_pkg::EDGE_W;
  localparam int PW = abd_pkg::PROD_W;
  localparam int SW = abd_pkg::SLOT_W;

  typedef logic [abd_pkg::CFG_IDX_W-1:0] cfg_idx_t;

  logic [3:0]  state_r, state_nxt;
  logic [15:0] thr_r, thr_nxt;
  logic [7:0]  stride_r, stride_nxt;
  logic [12:0] img_w_r, img_w_nxt;
  logic [12:0] img_h_r, img_h_nxt;
  logic [7:0]  cls_cnt_r, cls_cnt_nxt;
  logic [31:0] anchor_r   [abd_pkg::ANCHORS_PER_SCALE];
  logic [31:0] anchor_nxt [abd_pkg::ANCHORS_PER_SCALE];

  logic [15:0]        ox_r, ox_nxt, oy_r, oy_nxt, sw_r, sw_nxt, sh_r, sh_nxt;
  logic [15:0]        obj_r, obj_nxt;
  logic signed [15:0] best_logit_r, best_logit_nxt;
  logic [6:0]         best_idx_r, best_idx_nxt;

  logic [2:0]           prob_sel_r, prob_sel_nxt;
  logic [9:0]           col_r, col_nxt, row_r, row_nxt;
  logic [SW-1:0]        slot_r, slot_nxt;
  logic signed [PW-1:0] prod_r, prod_nxt;
  logic signed [EW-1:0] cx_r, cx_nxt, cy_r, cy_nxt, e_r, e_nxt;
  logic [48:0]          hw_r, hw_nxt, hh_r, hh_nxt;
  logic [1:0]           k_r, k_nxt;
  logic [15:0]          edge_r   [4];
  logic [15:0]          edge_nxt [4];
  logic [15:0]          score_r, score_nxt;
  logic                        out_valid_r, out_valid_nxt;
  logic [abd_pkg::OUT_DATA_W-1:0] out_data_r, out_data_nxt;

  logic [abd_pkg::SIG_IDX_W-1:0] rom_addr;
  logic [15:0]                   rom_q_r;

  logic signed [15:0] in_logit;
  logic [9:0]         in_col, in_row;
  logic [SW-1:0]      in_slot;
  logic [7:0]         in_ch;
  logic               in_fire;

  logic [7:0]           cc_sat;
  logic [8:0]           last_ch;
  logic signed [26:0]   tx, ty;
  logic signed [33:0]   mul_a;
  logic [16:0]          mul_b;
  logic signed [PW-1:0] mul_p;
  logic [30:0]          score_sum;
  logic [31:0]          anchor_sel;
  logic signed [EW-1:0] e_base, e_half;
  logic [24:0]          e_round;
  logic [15:0]          e_bound, e_clip;

  assign in_logit = $signed(in_tdata[15:0]);
  assign in_col   = in_tdata[25:16];
  assign in_row   = in_tdata[35:26];
  assign in_slot  = in_tdata[37:36];
  assign in_ch    = in_tdata[45:38];

  assign in_tready  = (state_r == ST_IDLE);
  assign in_fire    = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  always_comb begin
    if (cls_cnt_r == 8'd0) begin
      cc_sat = 8'd1;
    end else if (cls_cnt_r > 8'(abd_pkg::MAX_CLASSES)) begin
      cc_sat = 8'(abd_pkg::MAX_CLASSES);
    end else begin
      cc_sat = cls_cnt_r;
    end
  end
  assign last_ch = 9'd4 + {1'b0, cc_sat};

  assign rom_addr = (state_r == ST_CLSRD) ? abd_pkg::sig_index(best_logit_r)
                                          : abd_pkg::sig_index(in_logit);

  assign tx = $signed({2'b0, col_r, 15'd0}) + $signed({10'd0, ox_r, 1'b0}) - 27'sd16384;
  assign ty = $signed({2'b0, row_r, 15'd0}) + $signed({10'd0, oy_r, 1'b0}) - 27'sd16384;
  assign anchor_sel = anchor_r[slot_r];

  // shared multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_r)
      ST_SCORE: begin
        mul_a = {18'd0, obj_r};
        mul_b = {1'b0, rom_q_r};
      end
      ST_MCX: begin
        mul_a = {{7{tx[26]}}, tx};
        mul_b = {9'd0, stride_r};
      end
      ST_MCY: begin
        mul_a = {{7{ty[26]}}, ty};
        mul_b = {9'd0, stride_r};
      end
      ST_MW2: begin
        mul_a = {17'd0, sw_r, 1'b0};
        mul_b = {sw_r, 1'b0};
      end
      ST_MHW: begin
        mul_a = prod_r[33:0];
        mul_b = {1'b0, anchor_sel[31:16]};
      end
      ST_MH2: begin
        mul_a = {17'd0, sh_r, 1'b0};
        mul_b = {sh_r, 1'b0};
      end
      ST_MHH: begin
        mul_a = prod_r[33:0];
        mul_b = {1'b0, anchor_sel[15:0]};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end
  assign mul_p = mul_a * $signed({1'b0, mul_b});

  assign score_sum = prod_r[30:0] + 31'd16384;

  assign e_base  = k_r[0] ? cy_r : cx_r;
  assign e_half  = k_r[0] ? EW'(hh_r) : EW'(hw_r);
  assign e_bound = k_r[0] ? abd_pkg::clip_bound(img_h_r) : abd_pkg::clip_bound(img_w_r);
  assign e_round = {1'b0, e_r[54:31]} + {24'd0, e_r[30]};

  always_comb begin
    if (e_r <= 0) begin
      e_clip = 16'd0;
    end else if (e_round > {9'd0, e_bound}) begin
      e_clip = e_bound;
    end else begin
      e_clip = e_round[15:0];
    end
  end

  always_comb begin
    state_nxt      = state_r;
    thr_nxt        = thr_r;
    stride_nxt     = stride_r;
    img_w_nxt      = img_w_r;
    img_h_nxt      = img_h_r;
    cls_cnt_nxt    = cls_cnt_r;
    anchor_nxt     = anchor_r;
    ox_nxt         = ox_r;
    oy_nxt         = oy_r;
    sw_nxt         = sw_r;
    sh_nxt         = sh_r;
    obj_nxt        = obj_r;
    best_logit_nxt = best_logit_r;
    best_idx_nxt   = best_idx_r;
    prob_sel_nxt   = prob_sel_r;
    col_nxt        = col_r;
    row_nxt        = row_r;
    slot_nxt       = slot_r;
    prod_nxt       = mul_p;
    cx_nxt         = cx_r;
    cy_nxt         = cy_r;
    e_nxt          = e_r;
    hw_nxt         = hw_r;
    hh_nxt         = hh_r;
    k_nxt          = k_r;
    edge_nxt       = edge_r;
    score_nxt      = score_r;
    out_data_nxt   = out_data_r;
    out_valid_nxt  = out_valid_r && !out_tready;

    if (cfg_wr_en) begin
      unique case (cfg_index)
        abd_pkg::REG_SCORE_THRESHOLD: thr_nxt     = cfg_wdata[15:0];
        abd_pkg::REG_GRID_STRIDE:     stride_nxt  = cfg_wdata[7:0];
        abd_pkg::REG_IMAGE_WIDTH:     img_w_nxt   = cfg_wdata[12:0];
        abd_pkg::REG_IMAGE_HEIGHT:    img_h_nxt   = cfg_wdata[12:0];
        abd_pkg::REG_CLASS_COUNT:     cls_cnt_nxt = cfg_wdata[7:0];
        default: begin
          if (cfg_index >= abd_pkg::REG_ANCHOR_SIZE_0 &&
              cfg_index - abd_pkg::REG_ANCHOR_SIZE_0 <
                cfg_idx_t'(abd_pkg::ANCHORS_PER_SCALE)) begin
            anchor_nxt[SW'(cfg_index - abd_pkg::REG_ANCHOR_SIZE_0)] = cfg_wdata;
          end
        end
      endcase
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          if (in_ch <= abd_pkg::CH_OBJECTNESS) begin
            prob_sel_nxt = in_ch[2:0];
            state_nxt    = ST_SIGW;
          end else if ({1'b0, in_ch} <= last_ch) begin
            if (in_ch == abd_pkg::CH_FIRST_CLS) begin
              best_logit_nxt = in_logit;
              best_idx_nxt   = 7'd0;
            end else if (in_logit > best_logit_r) begin
              best_logit_nxt = in_logit;
              best_idx_nxt   = 7'(in_ch - abd_pkg::CH_FIRST_CLS);
            end
            if ({1'b0, in_ch} == last_ch) begin
              col_nxt   = in_col;
              row_nxt   = in_row;
              slot_nxt  = (in_slot > SW'(abd_pkg::ANCHORS_PER_SCALE - 1)) ?
                          SW'(abd_pkg::ANCHORS_PER_SCALE - 1) : in_slot;
              state_nxt = ST_CLSRD;
            end
          end
        end
      end
      ST_SIGW: begin
        unique case (prob_sel_r)
          abd_pkg::CH_OFFSET_X[2:0]: ox_nxt  = rom_q_r;
          abd_pkg::CH_OFFSET_Y[2:0]: oy_nxt  = rom_q_r;
          abd_pkg::CH_SIZE_W[2:0]:   sw_nxt  = rom_q_r;
          abd_pkg::CH_SIZE_H[2:0]:   sh_nxt  = rom_q_r;
          default:                   obj_nxt = rom_q_r;
        endcase
        state_nxt = ST_IDLE;
      end
      ST_CLSRD: state_nxt = ST_SCORE;
      ST_SCORE: state_nxt = ST_THR;
      ST_THR: begin
        score_nxt = score_sum[30:15];
        state_nxt = (score_sum[30:15] < thr_r) ? ST_IDLE : ST_MCX;
      end
      ST_MCX: state_nxt = ST_MCY;
      ST_MCY: begin
        cx_nxt    = {prod_r[35:0], 20'd0};
        state_nxt = ST_MW2;
      end
      ST_MW2: begin
        cy_nxt    = {prod_r[35:0], 20'd0};
        state_nxt = ST_MHW;
      end
      ST_MHW: state_nxt = ST_MH2;
      ST_MH2: begin
        hw_nxt    = prod_r[48:0];
        state_nxt = ST_MHH;
      end
      ST_MHH: state_nxt = ST_HHLD;
      ST_HHLD: begin
        hh_nxt    = prod_r[48:0];
        k_nxt     = 2'd0;
        state_nxt = ST_EDGE;
      end
      // left, top, right, bottom
      ST_EDGE: begin
        e_nxt     = k_r[1] ? e_base + e_half : e_base - e_half;
        state_nxt = ST_CLIP;
      end
      ST_CLIP: begin
        edge_nxt[k_r] = e_clip;
        k_nxt         = k_r + 2'd1;
        state_nxt     = (k_r == 2'd3) ? ST_EMIT : ST_EDGE;
      end
      ST_EMIT: begin
        if (!out_valid_r || out_tready) begin
          out_data_nxt  = {1'b0, best_idx_r, score_r, edge_r[3], edge_r[2],
                           edge_r[1], edge_r[0]};
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    rom_q_r    <= abd_pkg::SIG_TABLE[rom_addr];
    prob_sel_r <= prob_sel_nxt;
    col_r      <= col_nxt;
    row_r      <= row_nxt;
    slot_r     <= slot_nxt;
    prod_r     <= prod_nxt;
    cx_r       <= cx_nxt;
    cy_r       <= cy_nxt;
    e_r        <= e_nxt;
    hw_r       <= hw_nxt;
    hh_r       <= hh_nxt;
    k_r        <= k_nxt;
    edge_r     <= edge_nxt;
    score_r    <= score_nxt;
    out_data_r <= out_data_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      thr_r        <= 16'd16384;
      stride_r     <= 8'd8;
      img_w_r      <= 13'd640;
      img_h_r      <= 13'd640;
      cls_cnt_r    <= 8'd80;
      for (int i = 0; i < abd_pkg::ANCHORS_PER_SCALE; i++) begin
        anchor_r[i] <= 32'd0;
      end
      ox_r         <= 16'd0;
      oy_r         <= 16'd0;
      sw_r         <= 16'd0;
      sh_r         <= 16'd0;
      obj_r        <= 16'd0;
      best_logit_r <= 16'sh8000;
      best_idx_r   <= 7'd0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      thr_r        <= thr_nxt;
      stride_r     <= stride_nxt;
      img_w_r      <= img_w_nxt;
      img_h_r      <= img_h_nxt;
      cls_cnt_r    <= cls_cnt_nxt;
      anchor_r     <= anchor_nxt;
      ox_r         <= ox_nxt;
      oy_r         <= oy_nxt;
      sw_r         <= sw_nxt;
      sh_r         <= sh_nxt;
      obj_r        <= obj_nxt;
      best_logit_r <= best_logit_nxt;
      best_idx_r   <= best_idx_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

endmodule

`default_nettype wire
